### rtl/core/ssq_pkg.sv
// Shared types and constants for the half-step stepper sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package ssq_pkg;

  // field widths
  localparam int ANGLE_W    = 20;
  localparam int MAG_W      = 20;
  localparam int SPT_W      = 16;
  localparam int INTERVAL_W = 20;
  localparam int STEPS_W    = 23;
  localparam int ELAPSED_W  = 20;
  localparam int PHASE_W    = 3;
  localparam int MASK_W     = 8;
  localparam int COILS      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int OUT_W      = 32;

  // angle units: 360 degrees in 1/16 degree steps
  localparam int FULL_TURN_DEG       = 360;
  localparam int ANGLE_UNITS_PER_DEG = 16;
  localparam int TURN_UNITS          = FULL_TURN_DEG * ANGLE_UNITS_PER_DEG;
  // 5760 = 2^7 * 45: shift off the power of two, multiply the rest by
  // ceil(2^35 / 45); exact for any scaled product below 2^29
  localparam int DIV_SHIFT   = 7;
  localparam int DIV_K       = TURN_UNITS / (2 ** DIV_SHIFT);
  localparam int PROD_W      = MAG_W + SPT_W;
  localparam int SCALE_W     = PROD_W - DIV_SHIFT;
  localparam int RECIP_SHIFT = 35;
  localparam int RECIP_W     = 30;
  localparam int RPROD_W     = SCALE_W + RECIP_W;
  localparam int Q_W         = RPROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_K) - 64'd1) / 64'(DIV_K));

  localparam logic [PHASE_W-1:0]   PHASE_TOP   = 3'd7;
  localparam logic [STEPS_W-1:0]   STEPS_MAX   = {STEPS_W{1'b1}};
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  // register reset values
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 20'd1000;
  localparam logic [SPT_W-1:0]      SPT_RST      = 16'd4096;
  localparam logic [MASK_W-1:0]     MASK_A_RST   = 8'd131;
  localparam logic [MASK_W-1:0]     MASK_B_RST   = 8'd14;
  localparam logic [MASK_W-1:0]     MASK_C_RST   = 8'd56;
  localparam logic [MASK_W-1:0]     MASK_D_RST   = 8'd224;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_PERIOD    = 3'd0,
    CFG_STEPS_PER_TURN = 3'd1,
    CFG_COIL_A_MASK    = 3'd2,
    CFG_COIL_B_MASK    = 3'd3,
    CFG_COIL_C_MASK    = 3'd4,
    CFG_COIL_D_MASK    = 3'd5
  } ssq_cfg_idx_t;

  typedef enum logic {
    REQ_TICK   = 1'b0,
    REQ_ROTATE = 1'b1
  } ssq_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } ssq_state_t;

  typedef struct packed {
    logic load;      // latch the input beat
    logic mul;       // register scaled product
    logic div_step;  // register quotient from the reciprocal multiply
    logic emit;      // update state and load the result register
  } ssq_cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a beat
  } ssq_stat_t;

endpackage

`default_nettype wire

### rtl/core/ssq_ctrl.sv
// Sequencing FSM for the stepper sequencer: input handshake and datapath commands.
// Depends on ssq_pkg.
`default_nettype none

module ssq_ctrl
  import ssq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire logic      s_tuser,
  input  wire ssq_stat_t stat,
  output ssq_cmd_t       cmd
);

  ssq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (s_tuser == REQ_ROTATE) begin
            state_next = ST_MUL;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/ssq_dp.sv
// Datapath of the stepper sequencer: config registers, angle-to-steps
// multiply and reciprocal divide by 45, motion state, result register. Depends on ssq_pkg.
`default_nettype none

module ssq_dp
  import ssq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ssq_cmd_t              cmd,
  output ssq_stat_t                  stat,
  input  wire logic                  s_tuser,
  input  wire logic [ANGLE_W-1:0]    s_angle,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_W-1:0]           m_tdata
);

  // configuration
  logic [INTERVAL_W-1:0] tick_period;
  logic [SPT_W-1:0]      steps_per_turn;
  logic [MASK_W-1:0]     mask_a, mask_b, mask_c, mask_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period    <= INTERVAL_RST;
      steps_per_turn <= SPT_RST;
      mask_a         <= MASK_A_RST;
      mask_b         <= MASK_B_RST;
      mask_c         <= MASK_C_RST;
      mask_d         <= MASK_D_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TICK_PERIOD:    tick_period    <= cfg_data[INTERVAL_W-1:0];
        CFG_STEPS_PER_TURN: steps_per_turn <= cfg_data[SPT_W-1:0];
        CFG_COIL_A_MASK:    mask_a         <= cfg_data[MASK_W-1:0];
        CFG_COIL_B_MASK:    mask_b         <= cfg_data[MASK_W-1:0];
        CFG_COIL_C_MASK:    mask_c         <= cfg_data[MASK_W-1:0];
        CFG_COIL_D_MASK:    mask_d         <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // latched input beat
  logic               req_rot;
  logic [ANGLE_W-1:0] angle;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_rot <= s_tuser;
      angle   <= s_angle;
    end
  end

  // magnitude times steps_per_turn, low power of two dropped
  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;

  assign neg  = angle[ANGLE_W-1];
  assign mag  = neg ? (~angle + 1'b1) : angle;
  assign prod = PROD_W'(mag) * PROD_W'(steps_per_turn);

  // divide by DIV_K as a multiply by its scaled reciprocal
  logic [SCALE_W-1:0] scaled;
  logic [RPROD_W-1:0] recip_prod;
  logic [Q_W-1:0]     quo;

  assign recip_prod = RPROD_W'(scaled) * RPROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      scaled <= prod[PROD_W-1:DIV_SHIFT];
    end
    if (cmd.div_step) begin
      quo <= recip_prod[RPROD_W-1:RECIP_SHIFT];
    end
  end

  // motion state
  logic [PHASE_W-1:0]   phase;
  logic [STEPS_W-1:0]   steps_left;
  logic                 dir_cw;
  logic [ELAPSED_W-1:0] elapsed;
  logic [COILS-1:0]     coils;

  logic [PHASE_W-1:0]   phase_next;
  logic [STEPS_W-1:0]   steps_left_next;
  logic                 dir_cw_next;
  logic [ELAPSED_W-1:0] elapsed_next;
  logic [COILS-1:0]     coils_next;
  logic [ELAPSED_W-1:0] el_inc;
  logic                 do_step;
  logic [STEPS_W-1:0]   steps_new;

  assign el_inc    = (elapsed == ELAPSED_MAX) ? elapsed : elapsed + 1'b1;
  assign steps_new = (|quo[Q_W-1:STEPS_W]) ? STEPS_MAX : quo[STEPS_W-1:0];

  always_comb begin
    phase_next      = phase;
    steps_left_next = steps_left;
    dir_cw_next     = dir_cw;
    elapsed_next    = elapsed;
    coils_next      = coils;
    do_step         = 1'b0;
    if (req_rot) begin
      steps_left_next = steps_new;
      dir_cw_next     = !neg && (angle != '0);
    end else begin
      elapsed_next = el_inc;
      if ((steps_left != '0) && (el_inc >= tick_period)) begin
        do_step         = 1'b1;
        coils_next      = {mask_d[phase], mask_c[phase], mask_b[phase], mask_a[phase]};
        phase_next      = dir_cw ? phase + 1'b1 : phase + PHASE_TOP;
        steps_left_next = steps_left - 1'b1;
        elapsed_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= '0;
      steps_left <= '0;
      dir_cw     <= 1'b1;
      elapsed    <= '0;
      coils      <= '0;
    end else if (cmd.emit) begin
      phase      <= phase_next;
      steps_left <= steps_left_next;
      dir_cw     <= dir_cw_next;
      elapsed    <= elapsed_next;
      coils      <= coils_next;
    end
  end

  // result register
  logic [OUT_W-1:0] result_next;

  assign stat.out_free = !m_tvalid || m_tready;
  assign result_next   = OUT_W'({(steps_left_next == '0), dir_cw_next,
                                 steps_left_next, do_step, coils_next});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= result_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/stepper_half_step_sequencer.sv
// Top level of the half-step stepper sequencer: FSM plus datapath.
// Depends on ssq_pkg, ssq_ctrl and ssq_dp.
//
// Usage:
//  - Input stream (s_*): one beat per request. s_tuser is the request kind
//    (0 tick of one microsecond, 1 rotate); s_tdata[19:0] is the signed angle
//    in 1/16 degree, read only for a rotate.
//  - Output stream (m_*): exactly one beat per input beat, in order.
//  - Config channel (cfg_*): register index plus data, always ready.
//    Write only while the block is idle.
// Sequencing:
//  - Tick: the accepted beat goes straight to the emit step; the next beat is
//    accepted only once the FSM is back in idle.
//  - Rotate: a step for the 20x16 multiply, a step for the multiply by the
//    reciprocal of 45, then the emit step loads the result register. No new
//    beat is accepted until the emit step is done.
// Reset: synchronous; restores the register defaults, clears phase, step count,
//  elapsed counter and coil levels, sets clockwise and drops m_tvalid.
// Stall: the result register holds its beat while m_tready is low. The block
//  still accepts and works on the next input beat, then waits in the emit step
//  until the result register frees up.
`default_nettype none

module stepper_half_step_sequencer
  import ssq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [23:0]           s_tdata,   // [19:0] angle, [23:20] zero
  input  wire logic                  s_tuser,   // [0] req_type
  // output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_W-1:0]           m_tdata,   // [0] coil_a, [1] coil_b, [2] coil_c,
                                                // [3] coil_d, [4] stepped,
                                                // [27:5] steps_remaining,
                                                // [28] clockwise, [29] stopped,
                                                // [31:30] zero
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  ssq_cmd_t  cmd;
  ssq_stat_t stat;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  ssq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tuser   (s_tuser),
    .s_angle   (s_tdata[ANGLE_W-1:0]),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
